FILE: rtl/mlqwrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlqwrr_pkg;

  localparam int LEVELS      = 8;
  localparam int QUEUE_DEPTH = 16;

  localparam int LVL_W     = $clog2(LEVELS);
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CRD_W     = $clog2(LEVELS + 1);
  localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CRD_W-1:0] crd_t;
  typedef logic [ADDR_W-1:0] addr_t;

endpackage

`default_nettype wire

FILE: rtl/mlq_weighted_round_robin_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted request registers the id store read and moves to the response
// state; there the result register loads once out_valid or out_stall is low.
// in_stall holds off a new request until that result register is loaded.
// Reset (synchronous, rst_n low): cursor 0, heads and counts 0, credits full,
// no result pending. The id store is not cleared; no entry is read unwritten.
module mlq_weighted_round_robin_scheduler (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_op,
  input  wire  [7:0] in_process_id,
  input  wire  [2:0] in_priority_req,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_granted,
  output logic [7:0] out_granted_id,
  output logic [2:0] out_granted_level,
  output logic       out_dropped,
  output logic       out_all_empty
);

  mlqwrr_pkg::state_t state_r, state_nxt;

  mlqwrr_pkg::lvl_t cursor_r, cursor_nxt;
  mlqwrr_pkg::crd_t credit_r [mlqwrr_pkg::LEVELS];
  mlqwrr_pkg::crd_t credit_nxt [mlqwrr_pkg::LEVELS];
  mlqwrr_pkg::ptr_t head_r [mlqwrr_pkg::LEVELS];
  mlqwrr_pkg::ptr_t head_nxt [mlqwrr_pkg::LEVELS];
  mlqwrr_pkg::cnt_t count_r [mlqwrr_pkg::LEVELS];
  mlqwrr_pkg::cnt_t count_nxt [mlqwrr_pkg::LEVELS];

  logic [7:0] store_mem [mlqwrr_pkg::MEM_DEPTH];
  logic [7:0] rd_data_r;
  logic       wr_en;
  mlqwrr_pkg::addr_t wr_addr;
  logic       rd_en;
  mlqwrr_pkg::addr_t rd_addr;

  // per-request info carried to the response cycle
  logic              granted_r, granted_nxt;
  logic              dropped_r, dropped_nxt;
  mlqwrr_pkg::lvl_t  glevel_r, glevel_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_granted_r, out_granted_nxt;
  logic [7:0]        out_id_r, out_id_nxt;
  logic [2:0]        out_level_r, out_level_nxt;
  logic              out_dropped_r, out_dropped_nxt;
  logic              out_empty_r, out_empty_nxt;

  logic acc;
  logic any_busy;

  assign in_stall = (state_r != mlqwrr_pkg::S_IDLE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < mlqwrr_pkg::LEVELS; i++) begin
      if (count_r[i] != '0) any_busy = 1'b1;
    end
  end

  always_comb begin
    mlqwrr_pkg::lvl_t            lvl_idx;
    logic                        add_ok;
    logic [mlqwrr_pkg::PTR_W:0]  slot_sum;
    mlqwrr_pkg::ptr_t            slot;
    mlqwrr_pkg::lvl_t            cur;
    mlqwrr_pkg::lvl_t            found;
    logic                        hit;
    logic                        pulled;
    logic [mlqwrr_pkg::LVL_W:0]  cw;
    mlqwrr_pkg::crd_t            crd_new;
    logic                        all_zero;

    cursor_nxt  = cursor_r;
    credit_nxt  = credit_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    granted_nxt = granted_r;
    dropped_nxt = dropped_r;
    glevel_nxt  = glevel_r;
    wr_en       = 1'b0;
    wr_addr     = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;

    lvl_idx  = mlqwrr_pkg::LVL_W'(in_priority_req);
    add_ok   = 1'b0;
    slot_sum = '0;
    slot     = '0;
    cur      = '0;
    found    = '0;
    hit      = 1'b0;
    pulled   = 1'b0;
    cw       = '0;
    crd_new  = '0;
    all_zero = 1'b0;

    if (acc) begin
      granted_nxt = 1'b0;
      dropped_nxt = 1'b0;
      glevel_nxt  = '0;
      if (in_op == mlqwrr_pkg::OP_ADD) begin
        add_ok = (int'(in_priority_req) < mlqwrr_pkg::LEVELS) &&
                 (int'(count_r[lvl_idx]) < mlqwrr_pkg::QUEUE_DEPTH);
        if (add_ok) begin
          slot_sum = (mlqwrr_pkg::PTR_W + 1)'(head_r[lvl_idx]) +
                     (mlqwrr_pkg::PTR_W + 1)'(count_r[lvl_idx]);
          if (int'(slot_sum) >= mlqwrr_pkg::QUEUE_DEPTH) begin
            slot_sum = slot_sum - (mlqwrr_pkg::PTR_W + 1)'(mlqwrr_pkg::QUEUE_DEPTH);
          end
          slot    = slot_sum[mlqwrr_pkg::PTR_W-1:0];
          wr_en   = 1'b1;
          wr_addr = mlqwrr_pkg::ADDR_W'(lvl_idx) *
                    mlqwrr_pkg::ADDR_W'(mlqwrr_pkg::QUEUE_DEPTH) +
                    mlqwrr_pkg::ADDR_W'(slot);
          count_nxt[lvl_idx] = count_r[lvl_idx] + 1'b1;
        end else begin
          dropped_nxt = 1'b1;
        end
      end else begin
        cur = (int'(cursor_r) < mlqwrr_pkg::LEVELS) ? cursor_r : '0;
        // pull back to a higher level with work and credit
        for (int i = 0; i < mlqwrr_pkg::LEVELS; i++) begin
          if (!pulled && i < int'(cur) && count_r[i] != '0 && credit_r[i] != '0) begin
            cur    = mlqwrr_pkg::LVL_W'(i);
            pulled = 1'b1;
          end
        end
        // cyclic search for a nonempty level
        if (count_r[cur] == '0) begin
          for (int k = 1; k <= mlqwrr_pkg::LEVELS; k++) begin
            cw = (mlqwrr_pkg::LVL_W + 1)'(cur) + (mlqwrr_pkg::LVL_W + 1)'(k);
            if (int'(cw) >= mlqwrr_pkg::LEVELS) begin
              cw = cw - (mlqwrr_pkg::LVL_W + 1)'(mlqwrr_pkg::LEVELS);
            end
            if (!hit && count_r[cw[mlqwrr_pkg::LVL_W-1:0]] != '0) begin
              found = cw[mlqwrr_pkg::LVL_W-1:0];
              hit   = 1'b1;
            end
          end
          cur = hit ? found : '0;
        end
        if (count_r[cur] != '0) begin
          granted_nxt = 1'b1;
          glevel_nxt  = cur;
          rd_en       = 1'b1;
          rd_addr     = mlqwrr_pkg::ADDR_W'(cur) *
                        mlqwrr_pkg::ADDR_W'(mlqwrr_pkg::QUEUE_DEPTH) +
                        mlqwrr_pkg::ADDR_W'(head_r[cur]);
          head_nxt[cur] = (int'(head_r[cur]) == mlqwrr_pkg::QUEUE_DEPTH - 1) ?
                          '0 : head_r[cur] + 1'b1;
          count_nxt[cur] = count_r[cur] - 1'b1;
          crd_new = (credit_r[cur] != '0) ? credit_r[cur] - 1'b1 : '0;
          credit_nxt[cur] = crd_new;
          if (crd_new == '0) begin
            cur = (int'(cur) == mlqwrr_pkg::LEVELS - 1) ? '0 : cur + 1'b1;
          end
          all_zero = 1'b1;
          for (int i = 0; i < mlqwrr_pkg::LEVELS; i++) begin
            if (credit_nxt[i] != '0) all_zero = 1'b0;
          end
          if (all_zero) begin
            for (int i = 0; i < mlqwrr_pkg::LEVELS; i++) begin
              credit_nxt[i] = mlqwrr_pkg::CRD_W'(mlqwrr_pkg::LEVELS - i);
            end
          end
        end
        cursor_nxt = cur;
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    out_granted_nxt = out_granted_r;
    out_id_nxt      = out_id_r;
    out_level_nxt   = out_level_r;
    out_dropped_nxt = out_dropped_r;
    out_empty_nxt   = out_empty_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      mlqwrr_pkg::S_IDLE: begin
        if (acc) state_nxt = mlqwrr_pkg::S_RESP;
      end
      mlqwrr_pkg::S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = granted_r;
          out_id_nxt      = granted_r ? rd_data_r : 8'd0;
          out_level_nxt   = 3'(glevel_r);
          out_dropped_nxt = dropped_r;
          out_empty_nxt   = !any_busy;
          state_nxt       = mlqwrr_pkg::S_IDLE;
        end
      end
      default: state_nxt = mlqwrr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= in_process_id;
    if (rd_en) rd_data_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlqwrr_pkg::S_IDLE;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mlqwrr_pkg::LEVELS; i++) begin
        credit_r[i] <= mlqwrr_pkg::CRD_W'(mlqwrr_pkg::LEVELS - i);
        head_r[i]   <= '0;
        count_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      credit_r    <= credit_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    granted_r     <= granted_nxt;
    dropped_r     <= dropped_nxt;
    glevel_r      <= glevel_nxt;
    out_granted_r <= out_granted_nxt;
    out_id_r      <= out_id_nxt;
    out_level_r   <= out_level_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_empty_r   <= out_empty_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_granted_id    = out_id_r;
  assign out_granted_level = out_level_r;
  assign out_dropped       = out_dropped_r;
  assign out_all_empty     = out_empty_r;

endmodule

`default_nettype wire

FILE: tb/sv/mlq_weighted_round_robin_scheduler_test.sv
`timescale 1ns / 1ps

module mlq_weighted_round_robin_scheduler_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 467;
  localparam int PLAN_ROWS   = 10;

  typedef struct packed {
    logic              granted;
    logic [7:0]        id;
    mlqwrr_pkg::lvl_t  level;
    logic              dropped;
    logic              all_empty;
  } grant_t;

  typedef struct {
    logic       op;
    logic [7:0] id;
    logic [2:0] prio;
    int         rpt;
    bit         typed;
    grant_t     want;
  } plan_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_op;
  logic [7:0] in_process_id;
  logic [2:0] in_priority_req;
  logic       out_valid;
  logic       out_stall;
  logic       out_granted;
  logic [7:0] out_granted_id;
  logic [2:0] out_granted_level;
  logic       out_dropped;
  logic       out_all_empty;

  // scheduler image
  mlqwrr_pkg::lvl_t cursor;
  mlqwrr_pkg::crd_t credit [mlqwrr_pkg::LEVELS];
  mlqwrr_pkg::ptr_t fifo_head [mlqwrr_pkg::LEVELS];
  mlqwrr_pkg::cnt_t fifo_count [mlqwrr_pkg::LEVELS];
  logic [7:0]       fifo_mem [mlqwrr_pkg::LEVELS][mlqwrr_pkg::QUEUE_DEPTH];

  grant_t     grant_q [$];
  plan_row_t  plan [PLAN_ROWS];
  int         mismatch_count;
  int         cycle_count;
  int         src_gap_pct;
  int         sink_stall_pct;

  mlq_weighted_round_robin_scheduler u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_process_id    (in_process_id),
    .in_priority_req  (in_priority_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted      (out_granted),
    .out_granted_id   (out_granted_id),
    .out_granted_level(out_granted_level),
    .out_dropped      (out_dropped),
    .out_all_empty    (out_all_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mlq_weighted_round_robin_scheduler regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  function automatic void reset_image();
    cursor = '0;
    for (int i = 0; i < mlqwrr_pkg::LEVELS; i++) begin
      credit[i]     = mlqwrr_pkg::crd_t'(mlqwrr_pkg::LEVELS - i);
      fifo_head[i]  = '0;
      fifo_count[i] = '0;
    end
  endfunction

  function automatic grant_t schedule_step(logic op, logic [7:0] pid, logic [2:0] prio);
    grant_t r;
    int     cur;
    int     c;
    int     i;
    int     k;
    bit     hit;
    bit     all_zero;
    bit     none_left;
    r = '0;
    if (op == mlqwrr_pkg::OP_ADD) begin
      if (prio >= mlqwrr_pkg::LEVELS || fifo_count[prio] >= mlqwrr_pkg::QUEUE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        fifo_mem[prio][(fifo_head[prio] + fifo_count[prio]) % mlqwrr_pkg::QUEUE_DEPTH] = pid;
        fifo_count[prio] = fifo_count[prio] + 1'b1;
      end
    end else begin
      cur = cursor;
      for (i = 0; i < cur; i++) begin
        if (fifo_count[i] != 0 && credit[i] != 0) begin
          cur = i;
          break;
        end
      end
      if (fifo_count[cur] == 0) begin
        hit = 1'b0;
        for (k = 1; k <= mlqwrr_pkg::LEVELS; k++) begin
          c = (cur + k) % mlqwrr_pkg::LEVELS;
          if (fifo_count[c] != 0) begin
            hit = 1'b1;
            break;
          end
        end
        cur = hit ? c : 0;
      end
      if (fifo_count[cur] != 0) begin
        r.granted = 1'b1;
        r.id      = fifo_mem[cur][fifo_head[cur]];
        r.level   = mlqwrr_pkg::lvl_t'(cur);
        fifo_head[cur]  = mlqwrr_pkg::ptr_t'((fifo_head[cur] + 1) % mlqwrr_pkg::QUEUE_DEPTH);
        fifo_count[cur] = fifo_count[cur] - 1'b1;
        if (credit[cur] != 0) credit[cur] = credit[cur] - 1'b1;
        if (credit[cur] == 0) cur = (cur + 1 >= mlqwrr_pkg::LEVELS) ? 0 : cur + 1;
        all_zero = 1'b1;
        for (i = 0; i < mlqwrr_pkg::LEVELS; i++) begin
          if (credit[i] != 0) all_zero = 1'b0;
        end
        if (all_zero) begin
          for (i = 0; i < mlqwrr_pkg::LEVELS; i++) begin
            credit[i] = mlqwrr_pkg::crd_t'(mlqwrr_pkg::LEVELS - i);
          end
        end
      end
      cursor = mlqwrr_pkg::lvl_t'(cur);
    end
    none_left = 1'b1;
    for (i = 0; i < mlqwrr_pkg::LEVELS; i++) begin
      if (fifo_count[i] != 0) none_left = 1'b0;
    end
    r.all_empty = none_left;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic op, input logic [7:0] pid, input logic [2:0] prio,
                              input bit typed, input grant_t want);
    grant_t predicted;
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_process_id   <= pid;
    in_priority_req <= prio;
    do @(posedge clk); while (in_stall);
    predicted = schedule_step(op, pid, prio);
    grant_q.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    do @(negedge clk); while (grant_q.size() != 0);
  endtask

  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_granted, out_granted_id, out_granted_level, out_dropped, out_all_empty};
      if (grant_q.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        mismatch_count++;
      end else begin
        want = grant_q.pop_front();
        if (got.granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, got.granted);
          mismatch_count++;
        end
        if (got.id !== want.id) begin
          $error("granted_id: expected %0d, got %0d", want.id, got.id);
          mismatch_count++;
        end
        if (got.level !== want.level) begin
          $error("granted_level: expected %0d, got %0d", want.level, got.level);
          mismatch_count++;
        end
        if (got.dropped !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
          mismatch_count++;
        end
        if (got.all_empty !== want.all_empty) begin
          $error("all_empty: expected %0d, got %0d", want.all_empty, got.all_empty);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int     get_pct;
    int     focus_lvl;
    bit     focused;
    logic   op;
    logic [2:0] prio;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = mlqwrr_pkg::OP_ADD;
    in_process_id   = '0;
    in_priority_req = '0;
    src_gap_pct     = 22;
    sink_stall_pct  = 47;
    get_pct         = 50;
    focus_lvl       = 0;
    focused         = 1'b0;
    reset_image();

    plan = '{
      '{mlqwrr_pkg::OP_GET, 8'h00, 3'd0, 1,  1'b1, '{1'b0, 8'h00, 3'd0, 1'b0, 1'b1}},
      '{mlqwrr_pkg::OP_ADD, 8'hFF, 3'd7, 1,  1'b1, '{1'b0, 8'h00, 3'd0, 1'b0, 1'b0}},
      '{mlqwrr_pkg::OP_ADD, 8'h00, 3'd0, 1,  1'b1, '{1'b0, 8'h00, 3'd0, 1'b0, 1'b0}},
      '{mlqwrr_pkg::OP_GET, 8'h5A, 3'd5, 1,  1'b0, '0},
      '{mlqwrr_pkg::OP_GET, 8'hAA, 3'd2, 1,  1'b0, '0},
      '{mlqwrr_pkg::OP_GET, 8'hFF, 3'd7, 1,  1'b1, '{1'b0, 8'h00, 3'd0, 1'b0, 1'b1}},
      '{mlqwrr_pkg::OP_ADD, 8'hA0, 3'd0, 16, 1'b0, '0},
      '{mlqwrr_pkg::OP_ADD, 8'h55, 3'd0, 1,  1'b1, '{1'b0, 8'h00, 3'd0, 1'b1, 1'b0}},
      '{mlqwrr_pkg::OP_GET, 8'h00, 3'd0, 1,  1'b0, '0},
      '{mlqwrr_pkg::OP_ADD, 8'h3C, 3'd7, 1,  1'b0, '0}
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].rpt; k++) begin
        send_request(plan[r].op, plan[r].id + 8'(k), plan[r].prio, plan[r].typed,
                     plan[r].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      drain_requests();
      src_gap_pct    = (phase == 0) ? 22 : (phase == 1) ? 47 : 0;
      sink_stall_pct = (phase == 0) ? 47 : (phase == 1) ? 22 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 60 == 0) begin
          case ($urandom_range(0, 2))
            0: get_pct = 15;
            1: get_pct = 50;
            default: get_pct = 85;
          endcase
          focused   = $urandom_range(0, 1);
          focus_lvl = $urandom_range(0, mlqwrr_pkg::LEVELS - 2);
        end
        if (phase == 0 && n == PHASE_ITEMS / 2) drain_requests();
        op   = ($urandom_range(0, 99) < get_pct) ? mlqwrr_pkg::OP_GET : mlqwrr_pkg::OP_ADD;
        prio = focused ? 3'(focus_lvl + $urandom_range(0, 1)) : 3'($urandom_range(0, 7));
        send_request(op, 8'($urandom_range(0, 255)), prio, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mlq_weighted_round_robin_scheduler regression: pass");
    end else begin
      $display("mlq_weighted_round_robin_scheduler regression: fail");
    end
    $finish;
  end

endmodule
